// ===== hw/rtl/lkvc_pkg.sv =====
`default_nettype none

package lkvc_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lkvc_req_if.sv =====
`default_nettype none

interface lkvc_req_if;
  import lkvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lkvc_rsp_if.sv =====
`default_nettype none

interface lkvc_rsp_if;
  import lkvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lkvc_ctrl.sv =====
`default_nettype none

module lkvc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  req_valid_i,
  output logic                 req_ready_o,
  input  lkvc_pkg::ctrl_sts_t  sts_i,
  output lkvc_pkg::ctrl_cmd_t  cmd_o
);
  import lkvc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!sts_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.accept  = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.accept = req_valid_i;
      end
      ST_UPDATE: begin
        cmd_o.commit = !sts_i.out_full;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lkvc_datapath.sv =====
`default_nettype none

module lkvc_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [lkvc_pkg::CAP_W-1:0]            cfg_wdata_i,
  input  wire                                   req_op_i,
  input  wire  signed [lkvc_pkg::KEY_W-1:0]     req_key_i,
  input  wire  signed [lkvc_pkg::VAL_W-1:0]     req_value_i,
  input  lkvc_pkg::ctrl_cmd_t                   cmd_i,
  output lkvc_pkg::ctrl_sts_t                   sts_o,
  output logic                                  rsp_valid_o,
  input  wire                                   rsp_ready_i,
  output logic                                  rsp_found_o,
  output logic signed [lkvc_pkg::VAL_W-1:0]     rsp_read_value_o
);
  import lkvc_pkg::*;

  localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned WW = (CW > CAP_W) ? CW : CAP_W;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [KEY_W-1:0]   key_q  [ENTRIES];
  logic [VAL_W-1:0]   val_q  [ENTRIES];
  logic [RW-1:0]      rank_q [ENTRIES];
  logic [RW-1:0]      rank_d [ENTRIES];
  logic [CW-1:0]      count_q, count_d;
  logic [CAP_W-1:0]   cap_q;

  logic               op_q;
  logic [KEY_W-1:0]   req_key_q;
  logic [VAL_W-1:0]   req_val_q;
  logic [ENTRIES-1:0] hit_q, free_q, victim_q;
  logic [ENTRIES-1:0] hit_d, free_d, victim_d;

  logic               out_valid_q;
  logic               out_found_q;
  logic [VAL_W-1:0]   out_value_q;

  logic               hit;
  logic               full;
  logic               do_update;
  logic               write_entry;
  logic [ENTRIES-1:0] tgt;
  logic [CW-1:0]      thr;
  logic [RW-1:0]      hit_rank;
  logic [VAL_W-1:0]   hit_val;
  logic [CW-1:0]      count_m1;
  logic [WW-1:0]      cap_min1;

  assign count_m1 = count_q - CW'(1);
  assign cap_min1 = (cap_q == '0) ? WW'(1) : WW'(cap_q);
  assign full     = (count_q == CW'(ENTRIES)) || (WW'(count_q) >= cap_min1);

  always_comb begin
    free_d = ~valid_q & (valid_q + ENTRIES'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      hit_d[i]    = valid_q[i] && (key_q[i] == req_key_i);
      victim_d[i] = valid_q[i] && (CW'(rank_q[i]) == count_m1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= req_op_i;
      req_key_q <= req_key_i;
      req_val_q <= req_value_i;
      hit_q     <= hit_d;
      free_q    <= free_d;
      victim_q  <= victim_d;
    end
  end

  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank = hit_rank | (hit_q[i] ? rank_q[i] : '0);
      hit_val  = hit_val  | (hit_q[i] ? val_q[i]  : '0);
    end
  end

  assign hit         = |hit_q;
  assign do_update   = cmd_i.commit && (op_q == OP_PUT || hit);
  assign write_entry = cmd_i.commit && (op_q == OP_PUT);

  always_comb begin
    if (hit) begin
      tgt = hit_q;
      thr = CW'(hit_rank);
    end else if (full) begin
      tgt = victim_q;
      thr = count_m1;
    end else begin
      tgt = free_q;
      thr = count_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (do_update) begin
        if (tgt[i]) begin
          rank_d[i]  = '0;
          valid_d[i] = 1'b1;
        end else if (valid_q[i] && (CW'(rank_q[i]) < thr)) begin
          rank_d[i] = RW'(rank_q[i] + 1'b1);
        end
      end
    end
    if (write_entry && !hit && !full) begin
      count_d = count_q + CW'(1);
    end
    if (cfg_we_i) begin
      valid_d = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_q[i] <= rank_d[i];
      if (write_entry && tgt[i]) begin
        key_q[i] <= req_key_q;
        val_q[i] <= req_val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_found_q <= hit;
      if (op_q == OP_PUT) begin
        out_value_q <= req_val_q;
      end else if (hit) begin
        out_value_q <= hit_val;
      end else begin
        out_value_q <= MISS_VALUE;
      end
    end
  end

  assign sts_o.out_full  = out_valid_q && !rsp_ready_i;
  assign rsp_valid_o     = out_valid_q;
  assign rsp_found_o     = out_found_q;
  assign rsp_read_value_o = out_value_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache.sv =====
// Requests are taken only in idle; key compare over all entry cells runs in
// the transfer cycle, then the update state does rank update and write back
// and registers the result; a held result stalls it.
// Reset: valid marks and count clear at once, capacity returns to 16; keys,
// values and ranks stay undefined until written. No clearing pass.
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [lkvc_pkg::CAP_W-1:0]   cfg_wdata_i,
  lkvc_req_if.sink                     req_i,
  lkvc_rsp_if.source                   rsp_o
);
  import lkvc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_op_i         (req_i.op),
    .req_key_i        (req_i.key),
    .req_value_i      (req_i.value),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_found_o      (rsp_o.found),
    .rsp_read_value_o (rsp_o.read_value)
  );

endmodule

`default_nettype wire
